// ===== src/tape_machine_execute_unit_top_macros.svh =====
// Assertion macros for the tape machine execute unit RTL.
// Depends on nothing; included by files that carry assertions.
`ifndef TAPE_MACHINE_EXECUTE_UNIT_TOP_MACROS_SVH
`define TAPE_MACHINE_EXECUTE_UNIT_TOP_MACROS_SVH

// Asserts that an antecedent implies a consequent in the same cycle.
`define TME_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
    else $error(msg);

// Asserts that an antecedent implies a consequent in the following cycle.
`define TME_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/tme_pkg.sv =====
// Types and constants for the tape machine execute unit.
// Depends on nothing.
package tme_pkg;

  localparam logic [3:0] OP_MOVE = 4'd0;
  localparam logic [3:0] OP_ADD  = 4'd1;
  localparam logic [3:0] OP_OUT  = 4'd2;
  localparam logic [3:0] OP_IN   = 4'd3;
  localparam logic [3:0] OP_LOOP = 4'd4;
  localparam logic [3:0] OP_END  = 4'd5;
  localparam logic [3:0] OP_SET  = 4'd6;
  localparam logic [3:0] OP_SEEK = 4'd7;
  localparam logic [3:0] OP_XFER = 4'd8;
  localparam logic [3:0] OP_DIV  = 4'd9;
  localparam logic [3:0] OP_MOD  = 4'd10;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_LOW  = 2'd1;
  localparam logic [1:0] ST_HIGH = 2'd2;
  localparam logic [1:0] ST_DIV0 = 2'd3;

  localparam int INSTR_W = 4 + 16 + 17 + 16 + 16 + 16 + 9 + 9 + 1 + 8;

  typedef struct packed {
    logic [3:0]         operation;
    logic [15:0]        ip;
    logic signed [16:0] arg;
    logic [15:0]        run_count;
    logic signed [15:0] cell_offset;
    logic signed [15:0] target_offset;
    logic signed [8:0]  factor;
    logic signed [8:0]  bias;
    logic               first_target;
    logic [7:0]         in_byte;
  } instr_t;

  typedef struct packed {
    logic [16:0] next_ip;
    logic        out_valid;
    logic [7:0]  out_byte;
    logic [1:0]  status;
  } result_t;

endpackage

// ===== src/tme_queue.sv =====
// Two-entry instruction queue between the front end and the execute engine.
// Depends on tme_pkg.
module tme_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            wr_valid,
  output logic            wr_ready,
  input  tme_pkg::instr_t wr_data,
  output logic            rd_valid,
  input  logic            rd_ready,
  output tme_pkg::instr_t rd_data
);
  tme_pkg::instr_t mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign wr_ready = (cnt_r != 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_data  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (wr_valid && wr_ready) begin
      mem_r[wp_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (wr_valid && wr_ready) begin
        wp_r <= ~wp_r;
      end
      if (rd_valid && rd_ready) begin
        rp_r <= ~rp_r;
      end
      cnt_r <= cnt_r + 2'(wr_valid && wr_ready) - 2'(rd_valid && rd_ready);
    end
  end
endmodule

// ===== src/tme_divider.sv =====
// Restoring 8-bit divider, one quotient bit a cycle.
// Depends on nothing.
module tme_divider (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic [7:0] dividend,
  input  logic [7:0] divisor,
  output logic       done,
  output logic [7:0] quotient,
  output logic [7:0] remainder
);
  logic [7:0] q_r, r_r, d_r;
  logic [3:0] cnt_r;
  logic       busy_r;
  logic [8:0] trial;

  assign trial     = {r_r, q_r[7]} - {1'b0, d_r};
  assign quotient  = q_r;
  assign remainder = r_r;
  assign done      = busy_r && (cnt_r == 4'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= 4'd0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= 4'd8;
      q_r    <= dividend;
      r_r    <= 8'd0;
      d_r    <= divisor;
    end else if (busy_r) begin
      if (cnt_r == 4'd0) begin
        busy_r <= 1'b0;
      end else begin
        cnt_r <= cnt_r - 4'd1;
        if (!trial[8]) begin
          r_r <= trial[7:0];
          q_r <= {q_r[6:0], 1'b1};
        end else begin
          r_r <= {r_r[6:0], q_r[7]};
          q_r <= {q_r[6:0], 1'b0};
        end
      end
    end
  end
endmodule

// ===== src/tme_engine.sv =====
// Execute engine: owns the tape memory, data pointer and transfer source.
// Depends on tme_pkg, tme_divider and the assertion macro header.
`include "tape_machine_execute_unit_top_macros.svh"
module tme_engine #(
  parameter int TAPE_DEPTH = 32768,
  parameter int CODE_DEPTH = 65536
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             ins_valid,
  output logic             ins_ready,
  input  tme_pkg::instr_t  ins,
  output logic             res_valid,
  input  logic             res_ready,
  output tme_pkg::result_t res
);
  localparam int AW = $clog2(TAPE_DEPTH);
  localparam int CW = $clog2(CODE_DEPTH);
  localparam int PW = AW + 2;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_READ, S_EXEC, S_SREAD, S_SCHK, S_SET,
    S_TREAD, S_TWRITE, S_DIV, S_RESULT
  } state_t;

  state_t              state_r;
  logic [7:0]          tape_r [TAPE_DEPTH];
  logic [AW-1:0]       raddr_r, waddr_r, dp_r, tgt_r;
  logic [7:0]          rdata_r, wdata_r, src_r;
  logic                we_r;
  tme_pkg::instr_t     cur_r;
  tme_pkg::result_t    res_r;
  logic [AW:0]         cnt_r;
  logic [AW-1:0]       cell_addr, tgt_addr;
  logic signed [PW:0]  move_nd;
  logic [7:0]          argb, prod8;
  logic [15:0]         prod;
  logic [16:0]         ip_inc, jump;
  logic [AW:0]         run_n;
  logic                div_start, div_done;
  logic [7:0]          div_q, div_r;

  assign cell_addr = dp_r + AW'(ins.cell_offset);
  assign tgt_addr  = dp_r + AW'(cur_r.target_offset);
  assign argb      = cur_r.arg[7:0];
  assign move_nd   = $signed({2'b00, dp_r}) + (PW+1)'(cur_r.arg);
  assign ip_inc    = {1'b0, cur_r.ip} + 17'd1;
  assign jump      = 17'({1'b0, CW'(cur_r.arg)}) + 17'd1;
  assign prod      = src_r * cur_r.factor[7:0];
  assign prod8     = prod[7:0];
  assign run_n     = (cur_r.run_count <= 16'd1) ? (AW+1)'(1) :
                     ({16'd0, cur_r.run_count} > 32'(TAPE_DEPTH)) ? (AW+1)'(TAPE_DEPTH) :
                     (AW+1)'(cur_r.run_count);
  assign div_start = (state_r == S_EXEC) &&
                     (cur_r.operation == tme_pkg::OP_DIV ||
                      cur_r.operation == tme_pkg::OP_MOD) && (argb != 8'd0);

  tme_divider u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(rdata_r),
    .divisor(argb), .done(div_done), .quotient(div_q), .remainder(div_r)
  );

  always_ff @(posedge clk) begin
    if (we_r) begin
      tape_r[waddr_r] <= wdata_r;
    end
    rdata_r <= tape_r[raddr_r];
  end

  assign ins_ready = (state_r == S_IDLE);
  assign res_valid = (state_r == S_RESULT);
  assign res       = res_r;

  // The memory read is registered; the read address is presented in the state
  // before the data is used, and staged writes land in the cycle after.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      cnt_r   <= '0;
      dp_r    <= '0;
      we_r    <= 1'b0;
      waddr_r <= '0;
      wdata_r <= 8'd0;
    end else begin
      we_r <= 1'b0;
      unique case (state_r)
        S_CLEAR: begin
          we_r    <= 1'b1;
          waddr_r <= cnt_r[AW-1:0];
          wdata_r <= 8'd0;
          cnt_r   <= cnt_r + 1'b1;
          if (cnt_r == (AW+1)'(TAPE_DEPTH - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (ins_valid) begin
            cur_r   <= ins;
            raddr_r <= cell_addr;
            state_r <= S_READ;
          end
        end
        S_READ: begin
          tgt_r   <= tgt_addr;
          res_r   <= '{next_ip: ip_inc, out_valid: 1'b0, out_byte: 8'd0,
                       status: tme_pkg::ST_OK};
          cnt_r   <= '0;
          state_r <= (cur_r.operation == tme_pkg::OP_SEEK) ? S_SREAD : S_EXEC;
        end
        S_EXEC: begin
          state_r <= S_RESULT;
          case (cur_r.operation) inside
            tme_pkg::OP_MOVE: begin
              if (move_nd < 0) begin
                res_r.status <= tme_pkg::ST_LOW;
              end else if (move_nd >= (PW+1)'(TAPE_DEPTH)) begin
                res_r.status <= tme_pkg::ST_HIGH;
              end else begin
                dp_r <= move_nd[AW-1:0];
              end
            end
            tme_pkg::OP_ADD: begin
              we_r <= 1'b1; waddr_r <= raddr_r; wdata_r <= rdata_r + argb;
            end
            tme_pkg::OP_OUT: begin
              res_r.out_valid <= 1'b1; res_r.out_byte <= rdata_r;
            end
            tme_pkg::OP_IN: begin
              we_r <= 1'b1; waddr_r <= raddr_r; wdata_r <= cur_r.in_byte;
            end
            tme_pkg::OP_LOOP: begin
              if (rdata_r == 8'd0) res_r.next_ip <= jump;
            end
            tme_pkg::OP_END: begin
              if (rdata_r != 8'd0) res_r.next_ip <= jump;
            end
            tme_pkg::OP_SET: begin
              cnt_r   <= '0;
              state_r <= S_SET;
            end
            tme_pkg::OP_XFER: begin
              if (cur_r.first_target) src_r <= rdata_r;
              raddr_r <= tgt_r;
              state_r <= S_TREAD;
            end
            tme_pkg::OP_DIV, tme_pkg::OP_MOD: begin
              if (argb == 8'd0) begin
                res_r.status <= tme_pkg::ST_DIV0;
              end else begin
                raddr_r <= tgt_r;
                state_r <= S_DIV;
              end
            end
            default: ;
          endcase
        end
        S_SET: begin
          we_r    <= 1'b1;
          waddr_r <= raddr_r + cnt_r[AW-1:0];
          wdata_r <= argb;
          cnt_r   <= cnt_r + 1'b1;
          if (cnt_r + 1'b1 == run_n) state_r <= S_RESULT;
        end
        S_TREAD: state_r <= S_TWRITE;
        S_TWRITE: begin
          we_r    <= 1'b1;
          waddr_r <= tgt_r;
          wdata_r <= (cur_r.run_count == 16'd1) ? (cur_r.bias[7:0] + prod8) :
                     (rdata_r + cur_r.bias[7:0] + prod8);
          state_r <= S_RESULT;
        end
        S_DIV: begin
          if (div_done) begin
            we_r    <= 1'b1;
            waddr_r <= tgt_r;
            wdata_r <= (cur_r.operation == tme_pkg::OP_DIV) ? (rdata_r + div_q) : div_r;
            state_r <= S_RESULT;
          end
        end
        S_SREAD: state_r <= S_SCHK;
        S_SCHK: begin
          if (rdata_r == 8'd0 || cnt_r == (AW+1)'(TAPE_DEPTH)) begin
            state_r <= S_RESULT;
          end else begin
            dp_r    <= dp_r + AW'(cur_r.arg);
            raddr_r <= dp_r + AW'(cur_r.arg) + AW'(cur_r.cell_offset);
            cnt_r   <= cnt_r + 1'b1;
            state_r <= S_SREAD;
          end
        end
        S_RESULT: begin
          if (res_ready) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  `TME_ASSERT_IMP(a_no_overlap, clk, rst_n, res_valid, !ins_ready, "result and accept overlap")
  `TME_ASSERT_NXT(a_take, clk, rst_n, ins_valid && ins_ready, state_r == S_READ, "accept lost")
  `TME_ASSERT_NXT(a_hold, clk, rst_n, res_valid && !res_ready, res_valid && $stable(res_r),
                  "result dropped")
endmodule

// ===== src/tme_front.sv =====
// Front end: registers input beats and pushes them into the queue.
// Depends on tme_pkg.
module tme_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            s_valid,
  output logic            s_ready,
  input  tme_pkg::instr_t s_data,
  output logic            q_valid,
  input  logic            q_ready,
  output tme_pkg::instr_t q_data
);
  logic            full_r;
  tme_pkg::instr_t hold_r;

  assign s_ready = !full_r || q_ready;
  assign q_valid = full_r;
  assign q_data  = hold_r;

  always_ff @(posedge clk) begin
    if (s_valid && s_ready) begin
      hold_r <= s_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_r <= 1'b0;
    end else if (s_ready) begin
      full_r <= s_valid;
    end
  end
endmodule

// ===== src/tape_machine_execute_unit_top.sv =====
// Tape machine execute unit: executes decoded instructions on a byte tape.
// Input beats arrive on in_*; one result beat per instruction leaves on out_*.
// After reset the tape is cleared one cell a cycle, all TAPE_DEPTH cells, and no
// beat is taken by the engine until that is done (the front queue may fill).
// A front register and a two-entry queue accept beats while the engine works;
// an idle engine takes a beat once it has passed the front register and queue.
// The engine first reads the cell of a beat it takes. Move, add, out, in, loop
// and end then go straight to the result, as does a zero divisor. Set writes
// its run of cells in turn, transfer reads and then writes its target, divide
// and modulo wait on the divider, and seek reads and checks a cell per stride.
// After the result beat is taken the engine returns to idle before the next.
// The engine handles one instruction at a time and takes no beat until it is
// through with the last; the single tape memory has one read, one write a cycle.
// A stalled out_tready holds the result; the front keeps filling until full.
module tape_machine_execute_unit_top #(
  parameter int TAPE_DEPTH = 32768,
  parameter int CODE_DEPTH = 65536
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // operation, ip, arg, run_count, cell_offset, target_offset, factor, bias,
  // in_byte (bits 0..110), zero padded
  input  logic [111:0] in_tdata,
  // first_target
  input  logic        in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // next_ip, out_byte, status (bits 0..26), zero padded
  output logic [31:0] out_tdata,
  // out_valid
  output logic        out_tuser
);
  tme_pkg::instr_t  in_ins, f_ins, q_ins;
  tme_pkg::result_t res;
  logic f_valid, f_ready, q_valid, q_ready;

  assign in_ins.operation     = in_tdata[3:0];
  assign in_ins.ip            = in_tdata[19:4];
  assign in_ins.arg           = in_tdata[36:20];
  assign in_ins.run_count     = in_tdata[52:37];
  assign in_ins.cell_offset   = in_tdata[68:53];
  assign in_ins.target_offset = in_tdata[84:69];
  assign in_ins.factor        = in_tdata[93:85];
  assign in_ins.bias          = in_tdata[102:94];
  assign in_ins.in_byte       = in_tdata[110:103];
  assign in_ins.first_target  = in_tuser;

  tme_front u_front (
    .clk(clk), .rst_n(rst_n), .s_valid(in_tvalid), .s_ready(in_tready),
    .s_data(in_ins), .q_valid(f_valid), .q_ready(f_ready), .q_data(f_ins)
  );

  tme_queue u_queue (
    .clk(clk), .rst_n(rst_n), .wr_valid(f_valid), .wr_ready(f_ready),
    .wr_data(f_ins), .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_ins)
  );

  tme_engine #(.TAPE_DEPTH(TAPE_DEPTH), .CODE_DEPTH(CODE_DEPTH)) u_engine (
    .clk(clk), .rst_n(rst_n), .ins_valid(q_valid), .ins_ready(q_ready),
    .ins(q_ins), .res_valid(out_tvalid), .res_ready(out_tready), .res(res)
  );

  assign out_tdata = {5'd0, res.status, res.out_byte, res.next_ip};
  assign out_tuser = res.out_valid;
endmodule

// ===== tb/tape_machine_execute_unit_top_tb.sv =====
// Self-checking testbench for the tape machine execute unit top level.
// Depends on tme_pkg and tape_machine_execute_unit_top; predicts every result beat.
`timescale 1ns / 1ps

module tape_machine_execute_unit_top_tb;

  localparam int TAPE_CELLS = 32768;
  localparam int CYCLE_LIMIT = 30000000;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [111:0] in_tdata;
  logic         in_tuser;
  logic         out_tvalid;
  logic         out_tready;
  logic [31:0]  out_tdata;
  logic         out_tuser;

  tape_machine_execute_unit_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

  // Shadow of the machine state.
  logic [7:0] tape_img [TAPE_CELLS];
  int         ptr_img;
  logic [7:0] xfer_src;

  tme_pkg::instr_t  instr_q[$];
  tme_pkg::result_t result_q[$];
  tme_pkg::instr_t  in_cur;
  int      errors;
  int      taken;
  int      cycles;
  logic    rx_hold;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int cell_addr(input logic signed [15:0] off);
    return (ptr_img + int'(off)) & (TAPE_CELLS - 1);
  endfunction

  task automatic execute_instr(input tme_pkg::instr_t it);
    tme_pkg::result_t r;
    int c, d, n, nd;
    logic [7:0] argb, dividend;
    c = cell_addr(it.cell_offset);
    d = cell_addr(it.target_offset);
    argb = it.arg[7:0];
    r.next_ip = {1'b0, it.ip} + 17'd1;
    r.out_valid = 1'b0;
    r.out_byte = 8'd0;
    r.status = tme_pkg::ST_OK;
    case (it.operation) inside
      tme_pkg::OP_MOVE: begin
        nd = ptr_img + int'(it.arg);
        if (nd < 0) r.status = tme_pkg::ST_LOW;
        else if (nd >= TAPE_CELLS) r.status = tme_pkg::ST_HIGH;
        else ptr_img = nd;
      end
      tme_pkg::OP_ADD: tape_img[c] = tape_img[c] + argb;
      tme_pkg::OP_OUT: begin
        r.out_valid = 1'b1;
        r.out_byte = tape_img[c];
      end
      tme_pkg::OP_IN: tape_img[c] = it.in_byte;
      tme_pkg::OP_LOOP: if (tape_img[c] == 8'd0) r.next_ip = {1'b0, it.arg[15:0]} + 17'd1;
      tme_pkg::OP_END: if (tape_img[c] != 8'd0) r.next_ip = {1'b0, it.arg[15:0]} + 17'd1;
      tme_pkg::OP_SET: begin
        n = (it.run_count <= 1) ? 1 : int'(it.run_count);
        if (n > TAPE_CELLS) n = TAPE_CELLS;
        for (int i = 0; i < n; i++) tape_img[(c + i) & (TAPE_CELLS - 1)] = argb;
      end
      tme_pkg::OP_SEEK: begin
        for (int k = 0; k < TAPE_CELLS; k++) begin
          if (tape_img[cell_addr(it.cell_offset)] == 8'd0) break;
          ptr_img = (ptr_img + int'(it.arg)) & (TAPE_CELLS - 1);
        end
      end
      tme_pkg::OP_XFER: begin
        if (it.first_target) xfer_src = tape_img[c];
        if (it.run_count == 16'd1)
          tape_img[d] = it.bias[7:0] + 8'(xfer_src * it.factor[7:0]);
        else
          tape_img[d] = tape_img[d] + it.bias[7:0] + 8'(xfer_src * it.factor[7:0]);
      end
      tme_pkg::OP_DIV, tme_pkg::OP_MOD: begin
        dividend = tape_img[c];
        if (argb == 8'd0) r.status = tme_pkg::ST_DIV0;
        else if (it.operation == tme_pkg::OP_DIV) tape_img[d] = tape_img[d] + dividend / argb;
        else tape_img[d] = dividend % argb;
      end
      default: ;
    endcase
    result_q.push_back(r);
  endtask

  task automatic report(input string what, input int got, input int want);
    $display("mismatch on %s: got %0d, expected %0d", what, got, want);
    errors++;
  endtask

  // Sender side.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        execute_instr(in_cur);
        taken++;
      end
      if (!(in_tvalid && !in_tready)) begin
        if (instr_q.size() > 0 &&
            !(($urandom_range(99) < 14) && !(taken >= 200 && taken < 350))) begin
          in_cur = instr_q.pop_front();
          in_tdata <= {1'b0, in_cur.in_byte, in_cur.bias, in_cur.factor,
                       in_cur.target_offset, in_cur.cell_offset, in_cur.run_count,
                       in_cur.arg, in_cur.ip, in_cur.operation};
          in_tuser <= in_cur.first_target;
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver side.
  always @(posedge clk) begin
    tme_pkg::result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (result_q.size() == 0) begin
        $display("result beat with nothing expected");
        errors++;
      end else begin
        want = result_q.pop_front();
        if (out_tdata[16:0] !== want.next_ip) report("next_ip", out_tdata[16:0], want.next_ip);
        if (out_tuser !== want.out_valid) report("out_valid", out_tuser, want.out_valid);
        if (out_tdata[24:17] !== want.out_byte)
          report("out_byte", out_tdata[24:17], want.out_byte);
        if (out_tdata[26:25] !== want.status) report("status", out_tdata[26:25], want.status);
      end
    end
    out_tready <= !rx_hold &&
                  (($urandom_range(99) >= 14) || (taken >= 200 && taken < 350));
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tape_machine_execute_unit_top test failed");
      $finish;
    end
  end

  // Long receiver hold-off so that the front queue fills and in_tready drops.
  initial begin
    rx_hold = 1'b0;
    wait (taken >= 500);
    @(posedge clk) rx_hold <= 1'b1;
    repeat (400) @(posedge clk);
    rx_hold <= 1'b0;
  end

  function automatic tme_pkg::instr_t mk(input logic [3:0] op, input int arg,
                                         input int coff = 0, input int run = 0,
                                         input int toff = 0);
    tme_pkg::instr_t it;
    it = '0;
    it.operation = op;
    it.ip = 16'($urandom);
    it.arg = 17'(arg);
    it.cell_offset = 16'(coff);
    it.run_count = 16'(run);
    it.target_offset = 16'(toff);
    it.in_byte = 8'($urandom);
    return it;
  endfunction

  function automatic int pick_small(input int lim, input int bits);
    if ($urandom_range(7) == 0) return int'($urandom) & ((1 << bits) - 1);
    return $urandom_range(2 * lim) - lim;
  endfunction

  task automatic queue_random(input int count);
    tme_pkg::instr_t it;
    int op, extra;
    for (int i = 0; i < count; i++) begin
      op = $urandom_range(40) == 0 ? $urandom_range(15, 11) : $urandom_range(10);
      it.operation = 4'(op);
      it.ip = 16'($urandom);
      it.arg = 17'(pick_small(12, 17));
      it.run_count = 16'($urandom_range(3) == 0 ? $urandom_range(1) : $urandom_range(8));
      if (op == tme_pkg::OP_SET && $urandom_range(20) == 0)
        it.run_count = 16'($urandom_range(300));
      if (op == tme_pkg::OP_SET && $urandom_range(150) == 0) it.run_count = 16'($urandom);
      it.cell_offset = 16'(pick_small(6, 16));
      it.target_offset = 16'(pick_small(6, 16));
      it.factor = 9'($urandom);
      it.bias = 9'($urandom);
      it.in_byte = 8'($urandom);
      it.first_target = 1'($urandom);
      if (op == tme_pkg::OP_SEEK && it.arg == 17'd0 && $urandom_range(20) != 0)
        it.arg = 17'd1;
      if (op == tme_pkg::OP_XFER) begin
        // A transfer group: the first beat latches the source cell.
        it.first_target = 1'b1;
        instr_q.push_back(it);
        extra = $urandom_range(3);
        for (int j = 0; j < extra; j++) begin
          it.first_target = 1'b0;
          it.target_offset = 16'(pick_small(6, 16));
          it.factor = 9'($urandom);
          it.bias = 9'($urandom);
          it.run_count = 16'($urandom_range(2));
          it.ip = it.ip + 16'd1;
          instr_q.push_back(it);
        end
      end else begin
        instr_q.push_back(it);
      end
    end
  endtask

  task automatic wait_drained();
    while (instr_q.size() > 0 || in_tvalid || result_q.size() > 0) @(posedge clk);
  endtask

  initial begin
    tme_pkg::instr_t it;
    errors = 0;
    taken = 0;
    cycles = 0;
    ptr_img = 0;
    xfer_src = 8'd0;
    for (int i = 0; i < TAPE_CELLS; i++) tape_img[i] = 8'd0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = 1'b0;
    out_tready = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part: bounds, jumps, edge bytes, zero divisors, runs, seeks, transfers and an unknown opcode.
    instr_q.push_back(mk(tme_pkg::OP_MOVE, -1));
    instr_q.push_back(mk(tme_pkg::OP_MOVE, 40000));
    instr_q.push_back(mk(tme_pkg::OP_MOVE, 32767));
    instr_q.push_back(mk(tme_pkg::OP_MOVE, -32767));
    instr_q.push_back(mk(tme_pkg::OP_LOOP, -1));
    instr_q.push_back(mk(tme_pkg::OP_ADD, 255, -32768));
    instr_q.push_back(mk(tme_pkg::OP_OUT, 0, -32768));
    instr_q.push_back(mk(tme_pkg::OP_END, 65535, 32767 + 1));
    instr_q.push_back(mk(tme_pkg::OP_END, 7, 0));
    it = mk(tme_pkg::OP_IN, 0, 1);
    it.in_byte = 8'hff;
    it.ip = 16'hffff;
    instr_q.push_back(it);
    instr_q.push_back(mk(tme_pkg::OP_SET, 200, 2, 0));
    instr_q.push_back(mk(tme_pkg::OP_SET, 3, 10, 5));
    instr_q.push_back(mk(tme_pkg::OP_SET, 9, 100, 40000));
    instr_q.push_back(mk(tme_pkg::OP_SEEK, 0, 0));
    instr_q.push_back(mk(tme_pkg::OP_SET, 0, 0, 1));
    instr_q.push_back(mk(tme_pkg::OP_SEEK, -3, 0));
    it = mk(tme_pkg::OP_XFER, 0, 1, 1, 4);
    it.first_target = 1'b1;
    it.factor = -9'sd255;
    it.bias = 9'sd255;
    instr_q.push_back(it);
    it.first_target = 1'b0;
    it.run_count = 16'd0;
    it.factor = 9'sd255;
    it.bias = -9'sd255;
    instr_q.push_back(it);
    instr_q.push_back(mk(tme_pkg::OP_DIV, 256, 1, 0, 5));
    instr_q.push_back(mk(tme_pkg::OP_DIV, 7, 1, 0, 5));
    instr_q.push_back(mk(tme_pkg::OP_MOD, 10, 1, 0, 6));
    instr_q.push_back(mk(tme_pkg::OP_MOD, 0, 1, 0, 6));
    instr_q.push_back(mk(tme_pkg::OP_OUT, 0, 6));
    instr_q.push_back(mk(4'd15, 0));
    wait_drained();

    queue_random(350);
    wait_drained();
    queue_random(350);
    wait_drained();
    repeat (100) @(posedge clk);

    if (errors == 0) begin
      $display("tape_machine_execute_unit_top test passed");
    end else begin
      $display("tape_machine_execute_unit_top test failed");
    end
    $finish;
  end

endmodule
